@@ design/generational_handle_table_core_macros.svh @@
// Assertion macros shared by the handle table modules.
// Each check samples on i_clk and is disabled while i_rst_n is low.
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define GHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define GHT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define GHT_ASSERT(label, prop, msg)

`define GHT_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

@@ design/ght_pkg.sv @@
package ght_pkg;

    localparam int GEN_W = 32;
    localparam logic [GEN_W-1:0] GEN_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_RETAIN      = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_REF_OVF = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_WDONE
    } t_state;

    // Controller to datapath: at most one member is high in any cycle.
    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
    } t_dp_st;

endpackage

@@ design/ght_ram.sv @@
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/ght_ctrl.sv @@
`include "generational_handle_table_core_macros.svh"

module ght_ctrl
    import ght_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_walk,
    input  logic   i_out_ready,
    input  t_dp_st i_st,
    output t_cmd   o_cmd,
    output logic   o_in_ready,
    output logic   o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_in_walk ? S_WALK : S_EXEC;
            end
            S_EXEC: begin
                if (out_free) n_state = S_IDLE;
            end
            S_WALK: begin
                if (i_st.walk_last) n_state = S_WDONE;
            end
            S_WDONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC:  o_cmd.commit = out_free;
            S_WALK:  o_cmd.walk   = 1'b1;
            S_WDONE: o_cmd.finish = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit || o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `GHT_ASSERT_IMPLY(a_load_free, o_cmd.commit || o_cmd.finish, !r_out_valid || i_out_ready, "result overwrites an untaken word")
    `GHT_ASSERT(a_walk_end, (r_state == S_WALK && i_st.walk_last) |=> (r_state == S_WDONE), "walk did not close")
    `GHT_ASSERT(a_word_source, $rose(r_out_valid) |-> $past(r_state == S_EXEC || r_state == S_WDONE), "word raised outside a result state")

endmodule

@@ design/ght_dp.sv @@
`include "generational_handle_table_core_macros.svh"

module ght_dp
    import ght_pkg::*;
#(
    parameter int SLOTS       = 256,
    parameter int REF_WIDTH   = 16,
    parameter int OWNER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_dp_st      o_st,
    input  logic [1:0]  i_opcode,
    input  logic [23:0] i_handle_slot,
    input  logic [31:0] i_handle_gen,
    input  logic [15:0] i_owner_id,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_out,
    output logic [31:0] o_generation_out,
    output logic [15:0] o_refs_out,
    output logic [8:0]  o_released_count,
    output logic [8:0]  o_active_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] NIL = CW'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    typedef struct packed {
        logic                   occ;
        logic [GEN_W-1:0]       gen;
        logic [CW-1:0]          link;
        logic [REF_WIDTH-1:0]   refs;
        logic [OWNER_WIDTH-1:0] owner;
    } t_entry;

    // control state
    logic [CW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_active, n_active;
    logic [SW-1:0] r_clr_idx, n_clr_idx;
    logic [SW-1:0] r_walk_idx, n_walk_idx;
    logic [CW-1:0] r_rel, n_rel;

    // latched item
    t_op                    r_op, n_op;
    logic [SW-1:0]          r_slot, n_slot;
    logic                   r_in_range, n_in_range;
    logic [GEN_W-1:0]       r_hgen, n_hgen;
    logic [OWNER_WIDTH-1:0] r_owner, n_owner;
    logic                   r_full, n_full;

    // result word
    t_status          r_status, n_status;
    logic [7:0]       r_slot_out, n_slot_out;
    logic [GEN_W-1:0] r_gen_out, n_gen_out;
    logic [15:0]      r_refs_out, n_refs_out;
    logic [8:0]       r_rel_out, n_rel_out;
    logic [8:0]       r_active_out, n_active_out;

    logic          wr_en, rd_en;
    logic [SW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_q;

    logic [REF_WIDTH-1:0] dec_refs;
    logic                 freed;
    logic [GEN_W-1:0]     bump_gen;
    t_entry               drop_entry;
    logic                 handle_ok;
    logic                 walk_match;
    logic                 in_alloc;

    ght_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q)
    );

    // one reference off the entry just read; free it at zero
    always_comb begin
        dec_refs = (rd_q.refs != '0) ? rd_q.refs - REF_WIDTH'(1) : rd_q.refs;
        freed    = (dec_refs == '0);
        bump_gen = (rd_q.gen == GEN_MAX) ? GEN_W'(1) : rd_q.gen + GEN_W'(1);
        drop_entry       = rd_q;
        drop_entry.refs  = dec_refs;
        if (freed) begin
            drop_entry.occ  = 1'b0;
            drop_entry.gen  = bump_gen;
            drop_entry.link = r_free_head;
        end
    end

    assign handle_ok  = r_in_range && rd_q.occ && (rd_q.gen == r_hgen);
    assign walk_match = rd_q.occ && (rd_q.owner == r_owner);
    assign in_alloc   = (i_opcode == OP_ALLOC);

    assign o_st.clr_last  = (r_clr_idx == LAST_SLOT);
    assign o_st.walk_last = (r_walk_idx == LAST_SLOT);

    always_comb begin
        n_free_head  = r_free_head;
        n_active     = r_active;
        n_clr_idx    = r_clr_idx;
        n_walk_idx   = r_walk_idx;
        n_rel        = r_rel;
        n_op         = r_op;
        n_slot       = r_slot;
        n_in_range   = r_in_range;
        n_hgen       = r_hgen;
        n_owner      = r_owner;
        n_full       = r_full;
        n_status     = r_status;
        n_slot_out   = r_slot_out;
        n_gen_out    = r_gen_out;
        n_refs_out   = r_refs_out;
        n_rel_out    = r_rel_out;
        n_active_out = r_active_out;
        wr_en        = 1'b0;
        wr_addr      = r_slot;
        wr_data      = rd_q;
        rd_en        = 1'b0;
        rd_addr      = '0;

        if (i_cmd.clear) begin
            wr_en        = 1'b1;
            wr_addr      = r_clr_idx;
            wr_data      = '0;
            wr_data.gen  = GEN_W'(1);
            wr_data.link = CW'(r_clr_idx) + CW'(1);
            n_clr_idx    = r_clr_idx + SW'(1);
        end

        if (i_cmd.accept) begin
            n_op       = t_op'(i_opcode);
            n_in_range = ({1'b0, i_handle_slot} < 25'(SLOTS));
            n_hgen     = i_handle_gen;
            n_owner    = OWNER_WIDTH'(i_owner_id);
            n_full     = (r_free_head == NIL);
            n_slot     = in_alloc ? r_free_head[SW-1:0] : i_handle_slot[SW-1:0];
            n_walk_idx = '0;
            n_rel      = '0;
            rd_addr    = (i_opcode == OP_RELEASE_ALL) ? '0 : n_slot;
            rd_en      = !(in_alloc && (r_free_head == NIL));
        end

        if (i_cmd.commit) begin
            n_status   = ST_OK;
            n_slot_out = '0;
            n_gen_out  = '0;
            n_refs_out = '0;
            unique case (r_op)
                OP_ALLOC: begin
                    if (r_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en         = 1'b1;
                        wr_data.occ   = 1'b1;
                        wr_data.link  = NIL;
                        wr_data.refs  = REF_WIDTH'(1);
                        wr_data.owner = r_owner;
                        n_free_head   = rd_q.link;
                        n_active      = r_active + CW'(1);
                        n_slot_out    = 8'(r_slot);
                        n_gen_out     = rd_q.gen;
                        n_refs_out    = 16'd1;
                    end
                end
                OP_RETAIN: begin
                    if (!handle_ok) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_slot_out = 8'(r_slot);
                        n_gen_out  = rd_q.gen;
                        if (rd_q.refs == REF_MAX) begin
                            n_status   = ST_REF_OVF;
                            n_refs_out = 16'(rd_q.refs);
                        end else begin
                            wr_en        = 1'b1;
                            wr_data.refs = rd_q.refs + REF_WIDTH'(1);
                            n_refs_out   = 16'(wr_data.refs);
                        end
                    end
                end
                OP_RELEASE: begin
                    if (!handle_ok) begin
                        n_status = ST_INVALID;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = drop_entry;
                        if (freed) begin
                            n_free_head = CW'(r_slot);
                            if (r_active != '0) n_active = r_active - CW'(1);
                        end
                        n_slot_out = 8'(r_slot);
                        n_gen_out  = rd_q.gen;
                        n_refs_out = 16'(dec_refs);
                    end
                end
                OP_RELEASE_ALL: begin
                    n_status = ST_OK;
                end
            endcase
            n_rel_out    = '0;
            n_active_out = 9'(n_active);
        end

        // one slot per cycle: retire the entry read last cycle, read the next
        if (i_cmd.walk) begin
            if (walk_match) begin
                wr_en   = 1'b1;
                wr_addr = r_walk_idx;
                wr_data = drop_entry;
                n_rel   = r_rel + CW'(1);
                if (freed) begin
                    n_free_head = CW'(r_walk_idx);
                    if (r_active != '0) n_active = r_active - CW'(1);
                end
            end
            rd_en      = !o_st.walk_last;
            rd_addr    = r_walk_idx + SW'(1);
            n_walk_idx = r_walk_idx + SW'(1);
        end

        if (i_cmd.finish) begin
            n_status     = ST_OK;
            n_slot_out   = '0;
            n_gen_out    = '0;
            n_refs_out   = '0;
            n_rel_out    = 9'(r_rel);
            n_active_out = 9'(r_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_active    <= '0;
            r_clr_idx   <= '0;
            r_walk_idx  <= '0;
            r_rel       <= '0;
        end else begin
            r_free_head <= n_free_head;
            r_active    <= n_active;
            r_clr_idx   <= n_clr_idx;
            r_walk_idx  <= n_walk_idx;
            r_rel       <= n_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_in_range   <= n_in_range;
        r_hgen       <= n_hgen;
        r_owner      <= n_owner;
        r_full       <= n_full;
        r_status     <= n_status;
        r_slot_out   <= n_slot_out;
        r_gen_out    <= n_gen_out;
        r_refs_out   <= n_refs_out;
        r_rel_out    <= n_rel_out;
        r_active_out <= n_active_out;
    end

    assign o_status         = r_status;
    assign o_slot_out       = r_slot_out;
    assign o_generation_out = r_gen_out;
    assign o_refs_out       = r_refs_out;
    assign o_released_count = r_rel_out;
    assign o_active_out     = r_active_out;

    `GHT_ASSERT_IMPLY(a_head_range, 1'b1, r_free_head <= NIL, "free head beyond nil")
    `GHT_ASSERT_IMPLY(a_full_count, r_free_head == NIL, r_active == CW'(SLOTS), "empty free list with spare slots")

endmodule

@@ design/generational_handle_table_core.sv @@
// Generational handle table: SLOTS slots, each holding an occupied flag, a 32-bit
// generation, a saturating reference count and an owner id, with freed slots
// kept on a LIFO free list. Opcode 0 allocates (status 2 when full), 1 checks a
// handle and adds a reference (status 3 when the count is saturated), 2 checks a
// handle and drops a reference, freeing the slot and bumping its generation at
// zero (never to 0), and 3 drops one reference from every slot of an owner.
// After reset the block sweeps the slot memory once to load its reset contents,
// with o_in_ready low throughout. Allocate, retain and release read the slot
// memory in the accept cycle, then in the execute state write the entry back
// and load the result register once the output register is free. Release-all
// walks the slots in ascending order one per cycle through the memory's single
// read and single write port. A new word is taken while the previous result
// still waits in the output register; a finished item holds there until taken.
module generational_handle_table_core
    import ght_pkg::*;
#(
    parameter int SLOTS       = 256,
    parameter int REF_WIDTH   = 16,
    parameter int OWNER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [23:0] i_handle_slot,
    input  logic [31:0] i_handle_gen,
    input  logic [15:0] i_owner_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_out,
    output logic [31:0] o_generation_out,
    output logic [15:0] o_refs_out,
    output logic [8:0]  o_released_count,
    output logic [8:0]  o_active_out
);

    t_cmd   cmd;
    t_dp_st dp_st;
    logic   in_walk;

    // release-all leaves the single read-modify-write path for the slot walk
    assign in_walk = (i_opcode == OP_RELEASE_ALL);

    // sequence: clear sweep, then accept / commit or accept / walk / finish
    ght_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_walk   (in_walk),
        .i_out_ready (i_out_ready),
        .i_st        (dp_st),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // slot memory, free list head, occupancy count and result register
    ght_dp #(
        .SLOTS       (SLOTS),
        .REF_WIDTH   (REF_WIDTH),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (dp_st),
        .i_opcode         (i_opcode),
        .i_handle_slot    (i_handle_slot),
        .i_handle_gen     (i_handle_gen),
        .i_owner_id       (i_owner_id),
        .o_status         (o_status),
        .o_slot_out       (o_slot_out),
        .o_generation_out (o_generation_out),
        .o_refs_out       (o_refs_out),
        .o_released_count (o_released_count),
        .o_active_out     (o_active_out)
    );

endmodule
